/* rtl/aho_pkg.sv */
// Shared types, constants and the sine table function of the additive harmonic oscillator.
package aho_pkg;

   // Field and datapath widths
   localparam int AMP_W        = 8;
   localparam int AMP_SLOTS    = 8;
   localparam int SINE_MAG_W   = 15;
   localparam int SINE_W       = 16;
   localparam int PROD_W       = 25;
   localparam int ACC_W        = 27;
   localparam int SAMPLE_W     = 19;
   localparam int SAMPLE_SHIFT = 8;
   localparam int STEP_W       = 32;
   localparam int AMPS_W       = 64;
   localparam int CSR_IDX_W    = 2;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 24;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MUTE       = 2'd2;

   // Register reset values
   localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd44739243;
   localparam logic [AMPS_W-1:0] AMPLITUDES_RESET = 64'h2025_2B33_4055_80FF;

   // Quarter-wave polynomial coefficients, Q30
   localparam logic [63:0] C1 = 64'd1686629713;
   localparam logic [63:0] C3 = 64'd693598668;
   localparam logic [63:0] C5 = 64'd85569306;
   localparam logic [63:0] C7 = 64'd5026995;
   localparam logic [63:0] C9 = 64'd172272;

   // Control that travels with each transaction down the cell chain
   typedef struct packed {
      logic valid;
      logic mute;
   } ctrl_type;

   // Sine magnitude of quarter-wave index r, scaled to 32767; evaluated at elaboration
   function automatic logic [SINE_MAG_W-1:0] sine_mag(input logic [63:0] r, input int qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = r << (30 - qbits);
      x2 = (x * x) >> 30;
      t  = C9;
      t  = C7 - ((x2 * t) >> 30);
      t  = C5 - ((x2 * t) >> 30);
      t  = C3 - ((x2 * t) >> 30);
      t  = C1 - ((x2 * t) >> 30);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[SINE_MAG_W-1:0];
   endfunction

endpackage

/* rtl/aho_cell.sv */
// One harmonic cell: forms k*phase, looks up its sine and adds the weighted term.
module aho_cell #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic [aho_pkg::AMP_W-1:0]            amp,
   input  aho_pkg::ctrl_type                    in_ctrl,
   input  logic [PHASE_BITS-1:0]                in_phase,
   input  logic [PHASE_BITS-1:0]                in_hphase,
   input  logic signed [aho_pkg::ACC_W-1:0]     in_acc,
   output aho_pkg::ctrl_type                    out_ctrl,
   output logic [PHASE_BITS-1:0]                out_phase,
   output logic [PHASE_BITS-1:0]                out_hphase,
   output logic signed [aho_pkg::ACC_W-1:0]     out_acc
);

   localparam int QB      = SINE_ADDR_BITS - 2;
   localparam int QUARTER = 1 << QB;

   // Sine magnitude at the top of the quarter wave
   localparam logic [aho_pkg::SINE_MAG_W-1:0] PEAK = aho_pkg::sine_mag(64'(QUARTER), QB);

   // Quarter-wave sine table; the top end is held in PEAK
   logic [aho_pkg::SINE_MAG_W-1:0] lut [QUARTER];

   for (genvar i = 0; i < QUARTER; i++) begin : g_lut
      assign lut[i] = aho_pkg::sine_mag(64'(i), QB);
   end

   logic [PHASE_BITS-1:0]              hphase;
   logic [SINE_ADDR_BITS-1:0]          addr;
   logic [1:0]                         quad;
   logic [QB:0]                        idx;
   logic [aho_pkg::SINE_MAG_W-1:0]     mag;
   logic signed [aho_pkg::SINE_W-1:0]  sine;
   logic signed [aho_pkg::PROD_W-1:0]  prod;

   aho_pkg::ctrl_type                  s1_ctrl_ff;
   logic [PHASE_BITS-1:0]              s1_phase_ff;
   logic [PHASE_BITS-1:0]              s1_hphase_ff;
   logic signed [aho_pkg::ACC_W-1:0]   s1_acc_ff;
   logic signed [aho_pkg::SINE_W-1:0]  s1_sine_ff;

   aho_pkg::ctrl_type                  s2_ctrl_ff;
   logic [PHASE_BITS-1:0]              s2_phase_ff;
   logic [PHASE_BITS-1:0]              s2_hphase_ff;
   logic signed [aho_pkg::ACC_W-1:0]   s2_acc_ff;

   // Step the harmonic phase and map it onto the quarter wave
   always_comb begin
      hphase = in_hphase + in_phase;
      addr   = hphase[PHASE_BITS-1 -: SINE_ADDR_BITS];
      quad   = addr[SINE_ADDR_BITS-1 -: 2];
      if (quad[0]) begin
         idx = (QB+1)'(QUARTER) - {1'b0, addr[QB-1:0]};
      end else begin
         idx = {1'b0, addr[QB-1:0]};
      end
      if (idx[QB]) begin
         mag = PEAK;
      end else begin
         mag = lut[idx[QB-1:0]];
      end
      if (quad[1]) begin
         sine = -$signed({1'b0, mag});
      end else begin
         sine = $signed({1'b0, mag});
      end
   end

   // Weight the sine by this harmonic's amplitude
   assign prod = s1_sine_ff * $signed({1'b0, amp});

   // Hold control state, clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
      end else if (en) begin
         s1_ctrl_ff <= in_ctrl;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   // Advance the payload through the two cell stages
   always_ff @(posedge clock) begin
      if (en) begin
         s1_phase_ff  <= in_phase;
         s1_hphase_ff <= hphase;
         s1_acc_ff    <= in_acc;
         s1_sine_ff   <= sine;
         s2_phase_ff  <= s1_phase_ff;
         s2_hphase_ff <= s1_hphase_ff;
         s2_acc_ff    <= s1_acc_ff + aho_pkg::ACC_W'(prod);
      end
   end

   assign out_ctrl   = s2_ctrl_ff;
   assign out_phase  = s2_phase_ff;
   assign out_hphase = s2_hphase_ff;
   assign out_acc    = s2_acc_ff;

endmodule

/* rtl/additive_harmonic_oscillator.sv */
// Top level of the additive harmonic oscillator: registers, phase accumulator, cell chain, output.
// One tick in gives one 19-bit Q4.15 sample out. The block takes one transaction per cycle
// sustained while the skid entry is free; each tick passes through the phase stage, the s1 and
// s2 stages of each of the HARMONICS harmonic cells and then the output register, which drives
// rsp_tvalid. Every harmonic cell owns its own sine table and one multiplier. A two-entry
// output stage (register plus skid) takes one more sample while a sample waits to be taken,
// and input ticks stall once the skid entry is full. The user must write the configuration
// registers through csr_we/csr_index/csr_wdata only while no tick is in flight; the block
// itself does not enforce this. With mute set a tick yields zero and leaves the phase as is.
module additive_harmonic_oscillator #(
   parameter int HARMONICS      = 8,
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [aho_pkg::REQ_DATA_W-1:0]      req_tdata,   // [0] advance
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [aho_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [18:0] sample
   input  logic                                csr_we,
   input  logic [aho_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aho_pkg::AMPS_W-1:0]          csr_wdata
);

   // Configuration registers
   logic [aho_pkg::STEP_W-1:0]  phase_step_ff;
   logic [aho_pkg::AMPS_W-1:0]  amps_ff;
   logic                        mute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= aho_pkg::PHASE_STEP_RESET;
         amps_ff       <= aho_pkg::AMPLITUDES_RESET;
         mute_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            aho_pkg::REG_PHASE_STEP: phase_step_ff <= csr_wdata[aho_pkg::STEP_W-1:0];
            aho_pkg::REG_AMPLITUDES: amps_ff       <= csr_wdata;
            aho_pkg::REG_MUTE:       mute_ff       <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Output stage state
   logic                                 out_valid_ff, out_valid_in;
   logic [aho_pkg::SAMPLE_W-1:0]         out_data_ff, out_data_in;
   logic                                 skid_valid_ff, skid_valid_in;
   logic [aho_pkg::SAMPLE_W-1:0]         skid_data_ff, skid_data_in;
   logic                                 adv;
   logic                                 accept;

   // Pipeline moves whenever the skid entry is free
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   // Phase accumulator and chain entry stage
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic                   front_valid_ff, front_valid_in;
   logic                   front_mute_ff;

   always_comb begin
      phase_in       = phase_ff;
      front_valid_in = front_valid_ff;
      if (adv) begin
         front_valid_in = req_tvalid;
      end
      if (accept && !mute_ff && req_tdata[0]) begin
         phase_in = phase_ff + PHASE_BITS'(phase_step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         front_valid_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_mute_ff <= mute_ff;
      end
   end

   // Harmonic cell chain
   aho_pkg::ctrl_type                  chain_ctrl   [HARMONICS+1];
   logic [PHASE_BITS-1:0]              chain_phase  [HARMONICS+1];
   logic [PHASE_BITS-1:0]              chain_hphase [HARMONICS+1];
   logic signed [aho_pkg::ACC_W-1:0]   chain_acc    [HARMONICS+1];

   assign chain_ctrl[0].valid = front_valid_ff;
   assign chain_ctrl[0].mute  = front_mute_ff;
   assign chain_phase[0]      = phase_ff;
   assign chain_hphase[0]     = '0;
   assign chain_acc[0]        = '0;

   for (genvar j = 0; j < HARMONICS; j++) begin : g_cell
      logic [aho_pkg::AMP_W-1:0] amp;

      // Harmonics beyond the register's slots carry zero amplitude
      if (j < aho_pkg::AMP_SLOTS) begin : g_amp
         assign amp = amps_ff[j*aho_pkg::AMP_W +: aho_pkg::AMP_W];
      end else begin : g_zero
         assign amp = '0;
      end

      aho_cell #(
         .PHASE_BITS     (PHASE_BITS),
         .SINE_ADDR_BITS (SINE_ADDR_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .amp        (amp),
         .in_ctrl    (chain_ctrl[j]),
         .in_phase   (chain_phase[j]),
         .in_hphase  (chain_hphase[j]),
         .in_acc     (chain_acc[j]),
         .out_ctrl   (chain_ctrl[j+1]),
         .out_phase  (chain_phase[j+1]),
         .out_hphase (chain_hphase[j+1]),
         .out_acc    (chain_acc[j+1])
      );
   end

   // Floor-shift the sum to Q4.15; the sum of eight terms always fits 19 bits
   logic                          tail_valid;
   logic [aho_pkg::SAMPLE_W-1:0]  tail_sample;
   logic signed [aho_pkg::ACC_W-1:0] tail_shifted;

   assign tail_valid   = chain_ctrl[HARMONICS].valid;
   assign tail_shifted = chain_acc[HARMONICS] >>> aho_pkg::SAMPLE_SHIFT;
   assign tail_sample  = chain_ctrl[HARMONICS].mute ? '0
                                                    : aho_pkg::SAMPLE_W'(tail_shifted);

   // Output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = tail_valid;
            out_data_in  = tail_sample;
         end
      end else if (adv && tail_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = tail_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(aho_pkg::RSP_DATA_W - aho_pkg::SAMPLE_W){1'b0}}, out_data_ff};

endmodule

/* tb/additive_harmonic_oscillator_tb.sv */
// Self-checking testbench for the additive harmonic oscillator: directed table, then random runs.
`timescale 1ns / 1ps

module additive_harmonic_oscillator_tb;

   // Run shape
   localparam int RAND_PHASES     = 10;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int PRESSURE_PHASE  = 2;
   localparam int PRESSURE_CYCLES = 300;
   localparam int TAIL_CYCLES     = 40;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Index that decodes to no register
   localparam logic [aho_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   // Quarter-wave sine polynomial, Q30
   localparam logic [63:0] K1 = 64'd1686629713;
   localparam logic [63:0] K3 = 64'd693598668;
   localparam logic [63:0] K5 = 64'd85569306;
   localparam logic [63:0] K7 = 64'd5026995;
   localparam logic [63:0] K9 = 64'd172272;

   localparam logic signed [31:0] SAMPLE_HI = 32'sd262143;
   localparam logic signed [31:0] SAMPLE_LO = -32'sd262144;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [aho_pkg::CSR_IDX_W-1:0]       idx;
      logic [aho_pkg::AMPS_W-1:0]          value;
      logic                                adv;
      logic                                typed;
      logic signed [aho_pkg::SAMPLE_W-1:0] sample;
   } plan_row_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [aho_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [aho_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_we     = 1'b0;
   logic [aho_pkg::CSR_IDX_W-1:0]    csr_index  = '0;
   logic [aho_pkg::AMPS_W-1:0]       csr_wdata  = '0;

   // Oscillator state mirrored by the predictor
   logic [aho_pkg::STEP_W-1:0]       osc_step  = aho_pkg::PHASE_STEP_RESET;
   logic [aho_pkg::AMPS_W-1:0]       osc_amps  = aho_pkg::AMPLITUDES_RESET;
   logic                             osc_mute  = 1'b0;
   logic [31:0]                      osc_phase = '0;

   logic signed [aho_pkg::SAMPLE_W-1:0] expected_samples [$];
   plan_row_type                        plan_q [$];
   int                                  mismatch_count = 0;
   bit                                  idle_en        = 1'b1;
   bit                                  pressure_req   = 1'b0;

   additive_harmonic_oscillator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Signed Q1.15 sine of a 10-bit table address
   function automatic logic signed [15:0] sine_at(input logic [9:0] addr);
      logic [63:0] r, x, x2, t, s, v;
      r = {56'd0, addr[7:0]};
      if (addr[8]) begin
         r = 64'd256 - r;
      end
      x  = r << 22;
      x2 = (x * x) >> 30;
      t  = K9;
      t  = K7 - ((x2 * t) >> 30);
      t  = K5 - ((x2 * t) >> 30);
      t  = K3 - ((x2 * t) >> 30);
      t  = K1 - ((x2 * t) >> 30);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return addr[9] ? -$signed({1'b0, v[14:0]}) : $signed({1'b0, v[14:0]});
   endfunction

   // Unless muted, advance the mirrored phase on adv and sum the eight harmonics
   function automatic logic signed [aho_pkg::SAMPLE_W-1:0] predict_sample(input logic adv);
      logic signed [31:0] sum;
      logic signed [31:0] scaled;
      logic [31:0]        ph;
      if (osc_mute) begin
         return '0;
      end
      if (adv) begin
         osc_phase = osc_phase + osc_step;
      end
      sum = 0;
      for (int k = 1; k <= aho_pkg::AMP_SLOTS; k++) begin
         ph  = osc_phase * 32'(k);
         sum = sum + $signed({1'b0, osc_amps[8*(k-1) +: 8]}) * sine_at(ph[31:22]);
      end
      scaled = sum >>> aho_pkg::SAMPLE_SHIFT;
      if (scaled > SAMPLE_HI) begin
         scaled = SAMPLE_HI;
      end
      if (scaled < SAMPLE_LO) begin
         scaled = SAMPLE_LO;
      end
      return scaled[aho_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic void add_tick(input logic adv, input logic typed,
                                    input logic signed [aho_pkg::SAMPLE_W-1:0] sample);
      plan_row_type row;
      row        = '0;
      row.kind   = ROW_TICK;
      row.adv    = adv;
      row.typed  = typed;
      row.sample = sample;
      plan_q.push_back(row);
   endfunction

   function automatic void add_write(input logic [aho_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [aho_pkg::AMPS_W-1:0] value);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.idx   = idx;
      row.value = value;
      plan_q.push_back(row);
   endfunction

   // Drain the block, then write one register and mirror it
   task automatic write_register(input logic [aho_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [aho_pkg::AMPS_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         aho_pkg::REG_PHASE_STEP: osc_step = value[aho_pkg::STEP_W-1:0];
         aho_pkg::REG_AMPLITUDES: osc_amps = value;
         aho_pkg::REG_MUTE:       osc_mute = value[0];
         default:                 ;
      endcase
      csr_we <= 1'b0;
   endtask

   // Offer one tick, wait for the transaction, queue its sample
   task automatic send_tick(input logic adv, input logic typed,
                            input logic signed [aho_pkg::SAMPLE_W-1:0] typed_sample);
      logic signed [aho_pkg::SAMPLE_W-1:0] predicted;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(aho_pkg::REQ_DATA_W-1){1'b0}}, adv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_sample(adv);
      expected_samples.push_back(typed ? typed_sample : predicted);
   endtask

   // Stimulus
   initial begin
      logic [31:0] step;
      logic [63:0] amps;
      logic        mute_bit;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Phase starts at zero, so every harmonic reads a zero sine
      add_tick(1'b0, 1'b1, 19'sd0);
      add_write(aho_pkg::REG_PHASE_STEP, 64'h4000_0000);
      add_write(aho_pkg::REG_AMPLITUDES, 64'h0000_0000_0000_00FF);
      add_tick(1'b1, 1'b1, 19'sd32639);
      // Harmonics 1 and 5 at full scale, same sign at the quarter points
      add_write(aho_pkg::REG_AMPLITUDES, 64'h0000_00FF_0000_00FF);
      add_tick(1'b0, 1'b1, 19'sd65278);
      add_tick(1'b1, 1'b1, 19'sd0);
      add_tick(1'b1, 1'b1, -19'sd65279);
      // Mute gives zero and freezes the phase even on advance
      add_write(aho_pkg::REG_MUTE, 64'd1);
      add_tick(1'b1, 1'b1, 19'sd0);
      add_tick(1'b0, 1'b1, 19'sd0);
      add_write(aho_pkg::REG_MUTE, 64'd0);
      add_tick(1'b0, 1'b1, -19'sd65279);
      add_write(aho_pkg::REG_PHASE_STEP, 64'h8000_0000);
      add_tick(1'b1, 1'b1, 19'sd65278);
      // Unknown index must change nothing
      add_write(REG_UNUSED, '1);
      add_tick(1'b0, 1'b1, 19'sd65278);
      add_write(aho_pkg::REG_AMPLITUDES, '1);
      add_write(aho_pkg::REG_PHASE_STEP, 64'd0);
      add_tick(1'b1, 1'b1, 19'sd0);
      add_write(aho_pkg::REG_PHASE_STEP, 64'd1);
      add_tick(1'b1, 1'b0, '0);
      add_tick(1'b1, 1'b0, '0);
      add_write(aho_pkg::REG_AMPLITUDES, 64'd0);
      add_tick(1'b1, 1'b1, 19'sd0);
      add_write(aho_pkg::REG_AMPLITUDES, aho_pkg::AMPLITUDES_RESET);
      add_write(aho_pkg::REG_PHASE_STEP, {32'd0, aho_pkg::PHASE_STEP_RESET});
      add_tick(1'b1, 1'b0, '0);
      add_tick(1'b1, 1'b0, '0);
      add_tick(1'b1, 1'b0, '0);
      add_tick(1'b0, 1'b0, '0);

      foreach (plan_q[i]) begin
         if (plan_q[i].kind == ROW_WRITE) begin
            write_register(plan_q[i].idx, plan_q[i].value);
         end else begin
            send_tick(plan_q[i].adv, plan_q[i].typed, plan_q[i].sample);
         end
      end

      // Random settings per phase, the last one without idling
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase == RAND_PHASES - 1) begin
            idle_en = 1'b0;
         end
         case ($urandom_range(0, 3))
            0:       step = $urandom_range(0, 32'h0010_0000);
            1:       step = $urandom_range(0, 32'h8000_0000);
            2:       step = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0;
            default: step = 32'h1 << $urandom_range(0, 31);
         endcase
         case ($urandom_range(0, 4))
            0:       amps = '1;
            1:       amps = '0;
            2:       amps = 64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7));
            default: amps = {$urandom, $urandom};
         endcase
         mute_bit = (phase != RAND_PHASES - 1) && ($urandom_range(0, 7) == 0);
         write_register(aho_pkg::REG_PHASE_STEP, {32'd0, step});
         write_register(aho_pkg::REG_AMPLITUDES, amps);
         write_register(aho_pkg::REG_MUTE, {63'd0, mute_bit});
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == PRESSURE_PHASE && n == 40) begin
               pressure_req = 1'b1;
            end
            send_tick($urandom_range(0, 3) != 0, 1'b0, '0);
         end
      end

      // Drain and let any stray result show up
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** additive_harmonic_oscillator: PASSED **");
      end else begin
         $display("** additive_harmonic_oscillator: FAILED **");
      end
      $finish;
   end

   // Result side: check each transaction, then pick next tready
   initial begin
      int                                  stall_left;
      logic signed [aho_pkg::SAMPLE_W-1:0] want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample %0d", $time,
                        $signed(rsp_tdata[aho_pkg::SAMPLE_W-1:0]));
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[aho_pkg::SAMPLE_W-1:0] !== want) begin
                  $display("%0t: sample mismatch: expected %0d, actual %0d", $time,
                           want, $signed(rsp_tdata[aho_pkg::SAMPLE_W-1:0]));
                  mismatch_count++;
               end
            end
         end
         if (stall_left == 0) begin
            if (pressure_req) begin
               stall_left   = PRESSURE_CYCLES;
               pressure_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 5);
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("** additive_harmonic_oscillator: FAILED **");
            $finish;
         end
      end
   end

endmodule
